// ----- design/qpt_pkg.sv -----
// qpt_pkg: shared types and constants of the quadrature position tracker.
// No dependencies; imported by qpt_datapath, qpt_ctrl and the top level.
`default_nettype none

package qpt_pkg;

   localparam int unsigned PosWidth   = 16;
   localparam int unsigned RepWidth   = 7;
   // 127 * position needs 16 + 7 bits
   localparam int unsigned DivWidth   = PosWidth + RepWidth;
   localparam int unsigned StepWidth  = 3;
   localparam logic [PosWidth-1:0] ResolutionReset = PosWidth'(1000);

   // decoder phases
   localparam logic [1:0] PhaseIdle  = 2'd0;
   localparam logic [1:0] PhaseALow  = 2'd1;
   localparam logic [1:0] PhaseBLow  = 2'd2;

   // pending transition marks
   localparam logic [1:0] MarkNone   = 2'd0;
   localparam logic [1:0] MarkUp     = 2'd1;
   localparam logic [1:0] MarkDown   = 2'd2;

   // input kinds
   localparam logic ModeSample   = 1'b0;
   localparam logic ModeRecenter = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCALE,
      ST_DIVIDE,
      ST_PUSH
   } state_type;

   typedef struct packed {
      logic accept;   // take pins, update phase and count
      logic load;     // load dividend 127*count and shifted divisor
      logic step;     // one restoring division step
      logic push;     // move result into the output register
   } cmd_type;

   typedef struct packed {
      logic step_done;   // current step is the last quotient bit
   } status_type;

endpackage

`default_nettype wire

// ----- design/qpt_datapath.sv -----
// qpt_datapath: phase decoder, position counter, resolution register,
// restoring divider for the report value and output payload register. Uses qpt_pkg.
`default_nettype none

module qpt_datapath
   import qpt_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             cmd,
   output status_type               status,
   input  wire logic                mode,
   input  wire logic                pin_a,
   input  wire logic                pin_b,
   input  wire logic                csr_we,
   input  wire logic [PosWidth-1:0] csr_data,
   output logic      [PosWidth-1:0] position,
   output logic      [RepWidth-1:0] report_value
);

   logic [PosWidth-1:0]   res_ff, res_in;
   logic [1:0]            phase_ff, phase_in;
   logic [1:0]            mark_ff, mark_in;
   logic [PosWidth-1:0]   count_ff, count_in;
   logic [DivWidth-1:0]   rem_ff, rem_in;
   logic [DivWidth-2:0]   dsor_ff, dsor_in;
   logic [RepWidth-1:0]   quo_ff, quo_in;
   logic [StepWidth-1:0]  step_ff, step_in;
   logic [PosWidth-1:0]   pos_out_ff, pos_out_in;
   logic [RepWidth-1:0]   rep_out_ff, rep_out_in;

   logic                  inc, dec;
   logic [PosWidth:0]     cand;
   logic                  ge;

   // phase decoder and position update
   always_comb begin
      phase_in = phase_ff;
      mark_in  = mark_ff;
      inc      = 1'b0;
      dec      = 1'b0;
      if (mode == ModeSample) begin
         case (phase_ff)
            PhaseIdle: begin
               if (pin_a && pin_b && (mark_ff != MarkNone)) begin
                  inc     = (mark_ff == MarkUp);
                  dec     = (mark_ff != MarkUp);
                  mark_in = MarkNone;
               end
               if (!pin_a) phase_in = PhaseALow;
               if (!pin_b) phase_in = PhaseBLow;   // B wins when both low
            end
            PhaseALow: begin
               if (pin_a && pin_b) phase_in = PhaseIdle;
               if (pin_a && !pin_b) begin
                  mark_in  = MarkUp;
                  phase_in = PhaseBLow;
               end
            end
            PhaseBLow: begin
               if (pin_a && pin_b) phase_in = PhaseIdle;
               if (!pin_a && pin_b) begin
                  mark_in  = MarkDown;
                  phase_in = PhaseALow;
               end
            end
            default: phase_in = PhaseIdle;
         endcase
      end

      if (mode == ModeRecenter) begin
         cand = {2'b00, res_ff[PosWidth-1:1]};
      end else if (inc) begin
         cand = {1'b0, count_ff} + (PosWidth+1)'(1);
      end else if (dec && (count_ff != '0)) begin
         cand = {1'b0, count_ff} - (PosWidth+1)'(1);
      end else begin
         cand = {1'b0, count_ff};
      end

      if (cand > {1'b0, res_ff}) begin
         count_in = res_ff;
      end else begin
         count_in = cand[PosWidth-1:0];
      end
   end

   // restoring divider, one quotient bit per step, MSB first
   assign ge = (rem_ff >= {1'b0, dsor_ff});

   always_comb begin
      rem_in     = rem_ff;
      dsor_in    = dsor_ff;
      quo_in     = quo_ff;
      step_in    = step_ff;
      pos_out_in = pos_out_ff;
      rep_out_in = rep_out_ff;
      if (cmd.load) begin
         // 127 * count = count * 128 - count
         rem_in  = {count_ff, (RepWidth)'(0)} - {(RepWidth)'(0), count_ff};
         dsor_in = {res_ff, (RepWidth-1)'(0)};
         quo_in  = '0;
         step_in = StepWidth'(RepWidth - 1);
      end else if (cmd.step) begin
         if (ge) rem_in = rem_ff - {1'b0, dsor_ff};
         dsor_in = dsor_ff >> 1;
         quo_in  = {quo_ff[RepWidth-2:0], ge};
         step_in = step_ff - StepWidth'(1);
      end
      if (cmd.push) begin
         pos_out_in = count_ff;
         rep_out_in = (res_ff == '0) ? '0 : quo_ff;
      end
   end

   assign res_in = csr_we ? csr_data : res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff   <= ResolutionReset;
         phase_ff <= PhaseIdle;
         mark_ff  <= MarkNone;
         count_ff <= '0;
      end else begin
         res_ff <= res_in;
         if (cmd.accept) begin
            phase_ff <= phase_in;
            mark_ff  <= mark_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      dsor_ff    <= dsor_in;
      quo_ff     <= quo_in;
      step_ff    <= step_in;
      pos_out_ff <= pos_out_in;
      rep_out_ff <= rep_out_in;
   end

   assign status.step_done = (step_ff == '0);
   assign position         = pos_out_ff;
   assign report_value     = rep_out_ff;

endmodule

`default_nettype wire

// ----- design/qpt_ctrl.sv -----
// qpt_ctrl: sequencer of the quadrature position tracker; owns the handshakes
// and the output valid flag, drives qpt_datapath by command. Uses qpt_pkg.
`default_nettype none

module qpt_ctrl
   import qpt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output cmd_type         cmd,
   input  wire status_type status
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.load = 1'b1;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.step = 1'b1;
            if (status.step_done) state_in = ST_PUSH;
         end
         ST_PUSH: begin
            // wait for the output register to drain
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (cmd.push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- design/quadrature_position_tracker.sv -----
// quadrature_position_tracker: top level, joins qpt_ctrl and qpt_datapath.
// Depends on qpt_pkg, qpt_ctrl, qpt_datapath.
//
//   channel | ports                         | payload
//   --------+-------------------------------+---------------------------------------
//   req     | req_tvalid/tready/tdata/tuser | tuser: mode; tdata: pin_a, pin_b
//   rsp     | rsp_tvalid/tready/tdata       | tdata: position[15:0], report_value[22:16]
//   csr     | csr_valid/ready/data          | resolution[15:0]
//
// Each item passes from transfer to result through accept, scale, seven
// division steps (one quotient bit each, from the restoring divider) and push.
// A new item is taken while the previous result waits in the output register.
// Synchronous active-high reset: phase, mark and count clear, resolution = 1000.
// A stalled result holds the sequencer in its push state until the output drains.
`default_nettype none

module quadrature_position_tracker
   import qpt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // [0] pin_a, [1] pin_b, [7:2] zero
   input  wire logic [0:0]  req_tuser,    // [0] mode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,    // [15:0] position, [22:16] report_value, [23] zero
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data
);

   cmd_type             cmd;
   status_type          status;
   logic [PosWidth-1:0] position;
   logic [RepWidth-1:0] report_value;

   assign csr_ready = 1'b1;

   qpt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   qpt_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .mode         (req_tuser[0]),
      .pin_a        (req_tdata[0]),
      .pin_b        (req_tdata[1]),
      .csr_we       (csr_valid & csr_ready),
      .csr_data     (csr_data),
      .position     (position),
      .report_value (report_value)
   );

   assign rsp_tdata = {1'b0, report_value, position};

endmodule

`default_nettype wire

// ----- design/qpt_checker.sv -----
// qpt_checker: port-level assertions for quadrature_position_tracker,
// attached by the bind statement at the end. Depends on the top level only.
`default_nettype none

module qpt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp_tdata changed while stalled");

   // one item at a time: no second transfer right after one
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req_tready high in the cycle after a transfer");

   // a zero position always scales to a zero report
   a_zero_report: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[15:0] == 16'd0) |-> (rsp_tdata[22:16] == 7'd0))
      else $error("nonzero report for zero position");

endmodule

bind quadrature_position_tracker qpt_checker u_qpt_checker (.*);

`default_nettype wire
